// File: rtl/ssp_pkg.sv
package ssp_pkg;

   // grid size
   localparam int NUM_STEPS = 16;
   localparam int NUM_ROWS  = 5;
   localparam int STEP_W    = $clog2(NUM_STEPS);

   // field widths
   localparam int MODE_W   = 3;
   localparam int COL_W    = 4;
   localparam int ROW_W    = 3;
   localparam int FREQ_W   = 10;
   localparam int POS_W    = 4;
   localparam int PERIOD_W = 9;
   localparam int ELAPSED_W = 9;

   // step interval limits
   localparam logic [PERIOD_W-1:0] INTERVAL_RESET      = 9'd150;
   localparam logic [PERIOD_W-1:0] INTERVAL_STEP       = 9'd20;
   localparam logic [PERIOD_W-1:0] INTERVAL_FAST_GUARD = 9'd60;
   localparam logic [PERIOD_W-1:0] INTERVAL_SLOW_GUARD = 9'd400;
   localparam logic [PERIOD_W-1:0] INTERVAL_MIN        = 9'd50;
   localparam logic [PERIOD_W-1:0] INTERVAL_MAX        = 9'd410;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX        = '1;

   // event codes
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 3'd0,
      MODE_TOGGLE = 3'd1,
      MODE_PLAY   = 3'd2,
      MODE_CLEAR  = 3'd3,
      MODE_FASTER = 3'd4,
      MODE_SLOWER = 3'd5
   } mode_type;

   // grid edit request
   typedef struct packed {
      logic             toggle;
      logic             clear;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
   } grid_cmd_type;

   // topmost active row of the looked-up column
   typedef struct packed {
      logic             hit;
      logic [ROW_W-1:0] row;
   } grid_hit_type;

   // note frequency of each row, rows past the table are silent
   function automatic logic [FREQ_W-1:0] row_freq(input logic [ROW_W-1:0] r);
      logic [FREQ_W-1:0] f;
      case (r)
         3'd0:    f = 10'd880;
         3'd1:    f = 10'd784;
         3'd2:    f = 10'd659;
         3'd3:    f = 10'd587;
         3'd4:    f = 10'd523;
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage

// File: rtl/ssp_grid.sv
module ssp_grid import ssp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  grid_cmd_type      cmd,
   input  logic [STEP_W-1:0] lookup_col,
   output grid_hit_type      lookup
);

   logic [NUM_ROWS-1:0] pattern_ff [NUM_STEPS];
   logic [NUM_ROWS-1:0] pattern_in [NUM_STEPS];
   logic                in_range;
   logic [NUM_ROWS-1:0] sel;

   assign in_range = (int'(cmd.column) < NUM_STEPS) && (int'(cmd.row) < NUM_ROWS);

   // per-cell flip on toggle, whole grid cleared at once
   always_comb begin
      for (int c = 0; c < NUM_STEPS; c++) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            if (cmd.clear) begin
               pattern_in[c][r] = 1'b0;
            end else if (cmd.toggle && in_range && int'(cmd.column) == c
                         && int'(cmd.row) == r) begin
               pattern_in[c][r] = ~pattern_ff[c][r];
            end else begin
               pattern_in[c][r] = pattern_ff[c][r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_STEPS; c++) begin
         if (reset) begin
            pattern_ff[c] <= '0;
         end else begin
            pattern_ff[c] <= pattern_in[c];
         end
      end
   end

   // lowest row index wins
   assign sel = pattern_ff[lookup_col];

   always_comb begin
      lookup = '0;
      for (int r = NUM_ROWS - 1; r >= 0; r--) begin
         if (sel[r]) begin
            lookup.hit = 1'b1;
            lookup.row = ROW_W'(r);
         end
      end
   end

endmodule

// File: rtl/step_sequencer_playhead.sv
// Looping step sequencer playhead. Every req_ item is one event (tick, cell
// toggle, play/stop, clear, faster, slower) and yields exactly one rsp_ item
// in the next cycle from the result register. One event is taken every cycle
// while req_stall is low: the whole update is a single pass from the event
// ports to the state and result registers, with the grid held in flip-flops
// and one column read per event. req_stall is high only while a result sits
// in the result register and rsp_stall holds it there; reset clears the grid.
module step_sequencer_playhead import ssp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [COL_W-1:0]    req_column,
   input  logic [ROW_W-1:0]    req_row,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_beep,
   output logic [ROW_W-1:0]    rsp_note_row,
   output logic [FREQ_W-1:0]   rsp_note_freq,
   output logic [POS_W-1:0]    rsp_position,
   output logic                rsp_running,
   output logic [PERIOD_W-1:0] rsp_period_ms
);

   logic                 accept;
   mode_type             mode;
   grid_cmd_type         grid_cmd;
   grid_hit_type         grid_hit;
   logic [STEP_W-1:0]    lookup_col;

   logic                 running_ff, running_in;
   logic [STEP_W-1:0]    pos_ff, pos_in, pos_next;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic [PERIOD_W-1:0]  interval_ff, interval_in;
   logic                 fire;
   logic                 beep_in;
   logic [STEP_W+POS_W-1:0] pos_wide;

   logic                 rsp_valid_ff;
   logic                 rsp_beep_ff;
   logic [ROW_W-1:0]     rsp_note_row_ff;
   logic [FREQ_W-1:0]    rsp_note_freq_ff;
   logic [POS_W-1:0]     rsp_position_ff;
   logic                 rsp_running_ff;
   logic [PERIOD_W-1:0]  rsp_period_ms_ff;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign mode      = mode_type'(req_mode);

   // playhead helpers
   assign pos_next    = (pos_ff == STEP_W'(NUM_STEPS - 1)) ? '0 : pos_ff + 1'b1;
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign lookup_col  = (mode == MODE_PLAY) ? '0 : pos_next;

   // grid edits
   always_comb begin
      grid_cmd        = '0;
      grid_cmd.column = req_column;
      grid_cmd.row    = req_row;
      grid_cmd.toggle = accept && (mode == MODE_TOGGLE);
      grid_cmd.clear  = accept && (mode == MODE_CLEAR);
   end

   ssp_grid u_grid (
      .clock      (clock),
      .reset      (reset),
      .cmd        (grid_cmd),
      .lookup_col (lookup_col),
      .lookup     (grid_hit)
   );

   // event update
   always_comb begin
      running_in  = running_ff;
      pos_in      = pos_ff;
      elapsed_in  = elapsed_ff;
      interval_in = interval_ff;
      fire        = 1'b0;
      case (mode)
         MODE_TICK: begin
            if (running_ff) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= interval_ff) begin
                  pos_in     = pos_next;
                  elapsed_in = '0;
                  fire       = 1'b1;
               end
            end
         end
         MODE_PLAY: begin
            running_in = !running_ff;
            elapsed_in = '0;
            if (!running_ff) begin
               pos_in = '0;
               fire   = 1'b1;
            end
         end
         MODE_FASTER: begin
            if (interval_ff > INTERVAL_FAST_GUARD) begin
               interval_in = interval_ff - INTERVAL_STEP;
            end
         end
         MODE_SLOWER: begin
            if (interval_ff < INTERVAL_SLOW_GUARD) begin
               interval_in = interval_ff + INTERVAL_STEP;
            end
         end
         default: begin
         end
      endcase
   end

   assign beep_in  = fire && grid_hit.hit;
   assign pos_wide = {{POS_W{1'b0}}, pos_in};

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         pos_ff      <= '0;
         elapsed_ff  <= '0;
         interval_ff <= INTERVAL_RESET;
      end else if (accept) begin
         running_ff  <= running_in;
         pos_ff      <= pos_in;
         elapsed_ff  <= elapsed_in;
         interval_ff <= interval_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_beep_ff      <= beep_in;
         rsp_note_row_ff  <= beep_in ? grid_hit.row : '0;
         rsp_note_freq_ff <= beep_in ? row_freq(grid_hit.row) : '0;
         rsp_position_ff  <= pos_wide[POS_W-1:0];
         rsp_running_ff   <= running_in;
         rsp_period_ms_ff <= interval_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_beep      = rsp_beep_ff;
   assign rsp_note_row  = rsp_note_row_ff;
   assign rsp_note_freq = rsp_note_freq_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_running   = rsp_running_ff;
   assign rsp_period_ms = rsp_period_ms_ff;

endmodule

// File: rtl/ssp_checker.sv
module ssp_checker import ssp_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [MODE_W-1:0]   req_mode,
   input logic [COL_W-1:0]    req_column,
   input logic [ROW_W-1:0]    req_row,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_beep,
   input logic [ROW_W-1:0]    rsp_note_row,
   input logic [FREQ_W-1:0]   rsp_note_freq,
   input logic [POS_W-1:0]    rsp_position,
   input logic                rsp_running,
   input logic [PERIOD_W-1:0] rsp_period_ms
);

   // input side only waits on a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a held result");

   // an accepted item shows a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   // silent result carries no note
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_beep |-> rsp_note_row == '0 && rsp_note_freq == '0)
      else $error("note fields set without beep");

   // a note only sounds while playing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beep |-> rsp_running)
      else $error("beep while stopped");

   // interval stays in its range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_period_ms >= INTERVAL_MIN && rsp_period_ms <= INTERVAL_MAX)
      else $error("step interval out of range");

endmodule

bind step_sequencer_playhead ssp_checker u_ssp_checker (.*);
